@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is active.
`define LIX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is active.
`define LIX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/lix_pkg.sv @@
package lix_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    // Multiplier operand slice handled per pipeline stage.
    localparam int MUL_CHUNK      = 16;
endpackage

@@ hdl/lix_ifs.sv @@
interface lix_in_if #(
    parameter int COORD_BITS = lix_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface lix_out_if #(
    parameter int COORD_BITS = lix_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
    logic signed [COORD_BITS-1:0] first_param;
    logic signed [COORD_BITS-1:0] second_param;

    modport source (
        output valid, found, cross_x, cross_y, first_param, second_param,
        input  ready
    );
    modport sink (
        input  valid, found, cross_x, cross_y, first_param, second_param,
        output ready
    );
endinterface

@@ hdl/lix_dly.sv @@
module lix_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_pipe[k] <= '0;
        end else if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];
endmodule

@@ hdl/lix_mul.sv @@
module lix_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [WA-1:0]   i_a,
    input  logic signed [WB-1:0]   i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import lix_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NCH = (WB + CH - 1) / CH;
    localparam int WX  = NCH * CH;
    localparam int WP  = WA + WB;

    logic signed [WX-1:0]   bx;
    logic signed [WA-1:0]   a_st   [NCH];
    logic signed [WX-1:0]   b_st   [NCH];
    logic signed [WP-1:0]   acc_st [NCH];
    logic signed [CH:0]     chunk  [NCH];
    logic signed [WA+CH:0]  pp     [NCH];
    logic signed [WP-1:0]   n_acc  [NCH];
    logic signed [WA-1:0]   r_a    [NCH-1];
    logic signed [WX-1:0]   r_b    [NCH-1];
    logic signed [WP-1:0]   r_acc  [NCH];

    assign bx = WX'(i_b);

    // One slice of b per stage; the top slice carries the sign.
    always_comb begin
        a_st[0]   = i_a;
        b_st[0]   = bx;
        acc_st[0] = '0;
        for (int k = 1; k < NCH; k++) begin
            a_st[k]   = r_a[k-1];
            b_st[k]   = r_b[k-1];
            acc_st[k] = r_acc[k-1];
        end
        for (int k = 0; k < NCH; k++) begin
            if (k == NCH - 1) begin
                chunk[k] = $signed({b_st[k][WX-1], b_st[k][k*CH +: CH]});
            end else begin
                chunk[k] = $signed({1'b0, b_st[k][k*CH +: CH]});
            end
            pp[k]    = a_st[k] * chunk[k];
            n_acc[k] = acc_st[k] + (WP'(pp[k]) <<< (k * CH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NCH; k++) r_acc[k] <= n_acc[k];
            for (int k = 0; k < NCH - 1; k++) begin
                r_a[k] <= a_st[k];
                r_b[k] <= b_st[k];
            end
        end
    end

    assign o_p = r_acc[NCH-1];
endmodule

@@ hdl/lix_div.sv @@
module lix_div #(
    parameter int WN = 101,
    parameter int WD = 67,
    parameter int WQ = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WN-1:0] i_n,
    input  logic signed [WD-1:0] i_d,
    output logic signed [WQ-1:0] o_q
);
    localparam int WR = WD + WQ + 1;
    localparam int WC = WN + WD + WQ;
    localparam logic [WQ-1:0] QMAX = {1'b0, {(WQ-1){1'b1}}};
    localparam logic [WQ-1:0] QMIN = {1'b1, {(WQ-1){1'b0}}};

    // Stage 0: magnitudes and signs.
    logic [WN-1:0] r_un;
    logic [WD-1:0] r_ud0;
    logic          r_neg0;
    logic          r_dz0;
    // Stage 1: range check against 2^WQ.
    logic [WR-1:0] r_rem1;
    logic [WD-1:0] r_ud1;
    logic          r_neg1;
    logic          r_dz1;
    logic          r_ovf1;
    // Bit stages, one quotient bit each, MSB first.
    logic [WR-1:0] rem_st [WQ];
    logic [WD-1:0] ud_st  [WQ];
    logic          neg_st [WQ];
    logic          dz_st  [WQ];
    logic          ovf_st [WQ];
    logic [WQ-1:0] q_st   [WQ];
    logic [WR-1:0] n_rem  [WQ];
    logic [WQ-1:0] n_q    [WQ];
    logic          ge     [WQ];
    logic [WR-1:0] r_rem  [WQ-1];
    logic [WD-1:0] r_ud   [WQ-1];
    logic          r_neg  [WQ];
    logic          r_dz   [WQ];
    logic          r_ovf  [WQ];
    logic [WQ-1:0] r_q    [WQ];
    logic signed [WQ-1:0] r_res;
    logic [WQ-1:0] qm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_un   <= i_n[WN-1] ? -i_n : i_n;
            r_ud0  <= i_d[WD-1] ? -i_d : i_d;
            r_neg0 <= i_n[WN-1] ^ i_d[WD-1];
            r_dz0  <= (i_d == '0);

            r_rem1 <= WR'(r_un);
            r_ud1  <= r_ud0;
            r_neg1 <= r_neg0;
            r_dz1  <= r_dz0;
            r_ovf1 <= WC'(r_un) >= (WC'(r_ud0) << WQ);
        end
    end

    always_comb begin
        rem_st[0] = r_rem1;
        ud_st[0]  = r_ud1;
        neg_st[0] = r_neg1;
        dz_st[0]  = r_dz1;
        ovf_st[0] = r_ovf1;
        q_st[0]   = '0;
        for (int j = 1; j < WQ; j++) begin
            rem_st[j] = r_rem[j-1];
            ud_st[j]  = r_ud[j-1];
            neg_st[j] = r_neg[j-1];
            dz_st[j]  = r_dz[j-1];
            ovf_st[j] = r_ovf[j-1];
            q_st[j]   = r_q[j-1];
        end
        for (int j = 0; j < WQ; j++) begin
            ge[j]    = rem_st[j] >= (WR'(ud_st[j]) << (WQ - 1 - j));
            n_rem[j] = ge[j] ? rem_st[j] - (WR'(ud_st[j]) << (WQ - 1 - j)) : rem_st[j];
            n_q[j]   = {q_st[j][WQ-2:0], ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < WQ; j++) begin
                r_neg[j] <= neg_st[j];
                r_dz[j]  <= dz_st[j];
                r_ovf[j] <= ovf_st[j];
                r_q[j]   <= n_q[j];
            end
            for (int j = 0; j < WQ - 1; j++) begin
                r_rem[j] <= n_rem[j];
                r_ud[j]  <= ud_st[j];
            end
        end
    end

    assign qm = r_q[WQ-1];

    // Apply sign, then clamp to the signed range; zero divisor gives zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dz[WQ-1]) begin
                r_res <= '0;
            end else if (r_ovf[WQ-1]) begin
                r_res <= r_neg[WQ-1] ? QMIN : QMAX;
            end else if (r_neg[WQ-1]) begin
                r_res <= (qm > QMIN) ? QMIN : -qm;
            end else begin
                r_res <= (qm > QMAX) ? QMAX : qm;
            end
        end
    end

    assign o_q = r_res;
endmodule

@@ hdl/line_intersection_2d_core.sv @@
//  channel | dir | handshake     | payload
//  i_in    | in  | valid / ready | two lines, start and end point each, signed fixed point
//  o_out   | out | valid / ready | found, crossing point, parameter on each line
//
//  One item enters per cycle while no result is held at the output; later items
//  follow earlier ones through the sliced multipliers and the two bit-per-stage
//  divider stages.
//  Reset clears the valid bits and the delay lines; the multiplier and divider
//  stages need no clearing.
//  A held result freezes the whole pipeline; nothing is dropped or repeated.
`include "assert_macros.svh"

module line_intersection_2d_core #(
    parameter int COORD_BITS = lix_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lix_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lix_in_if.sink     i_in,
    lix_out_if.source  o_out
);
    import lix_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int W1  = W + 1;          // coordinate difference
    localparam int WM  = 2 * W + 2;      // product of two differences
    localparam int WC  = 2 * W + 3;      // c term, determinant, squared length
    localparam int WX3 = 3 * W + 4;      // product for Cramer numerators
    localparam int WNX = 3 * W + 5;      // Cramer numerator
    localparam int WNP = WC + FRAC_BITS; // scaled dot product
    localparam int LM  = (W1 + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LD  = W + 3;
    localparam int D_AB    = LM + 1;
    localparam int D_DET   = LM;
    localparam int D_CRD   = 2 * LM + 2 + LD;
    localparam int D_XY    = LM + 2 + LD;
    localparam int D_FOUND = 2 * LD + LM + 2;
    localparam int D_VALID = 3 * LM + 2 * LD + 4;

    // Global advance: the pipeline moves unless a result is held at the output.
    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // ---------------- Stage 0: register points, form line coefficients
    logic                 r_v0;
    logic signed [W1-1:0] r_a1, r_b1, r_a2, r_b2;
    logic signed [W-1:0]  r_sx1, r_sy1, r_ex1, r_ey1, r_sx2, r_sy2, r_ex2, r_ey2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1  <= W1'(i_in.first_end_y) - W1'(i_in.first_start_y);
            r_b1  <= W1'(i_in.first_start_x) - W1'(i_in.first_end_x);
            r_a2  <= W1'(i_in.second_end_y) - W1'(i_in.second_start_y);
            r_b2  <= W1'(i_in.second_start_x) - W1'(i_in.second_end_x);
            r_sx1 <= i_in.first_start_x;
            r_sy1 <= i_in.first_start_y;
            r_ex1 <= i_in.first_end_x;
            r_ey1 <= i_in.first_end_y;
            r_sx2 <= i_in.second_start_x;
            r_sy2 <= i_in.second_start_y;
            r_ex2 <= i_in.second_end_x;
            r_ey2 <= i_in.second_end_y;
        end
    end

    // ---------------- M1: c terms and determinant
    logic signed [WM-1:0] p_a1x, p_b1y, p_a2x, p_b2y, p_a1b2, p_a2b1;

    lix_mul #(.WA(W1), .WB(W1)) u_m_a1x (.i_clk, .i_en(en), .i_a(r_a1),
        .i_b(W1'(r_sx1)), .o_p(p_a1x));
    lix_mul #(.WA(W1), .WB(W1)) u_m_b1y (.i_clk, .i_en(en), .i_a(r_b1),
        .i_b(W1'(r_sy1)), .o_p(p_b1y));
    lix_mul #(.WA(W1), .WB(W1)) u_m_a2x (.i_clk, .i_en(en), .i_a(r_a2),
        .i_b(W1'(r_sx2)), .o_p(p_a2x));
    lix_mul #(.WA(W1), .WB(W1)) u_m_b2y (.i_clk, .i_en(en), .i_a(r_b2),
        .i_b(W1'(r_sy2)), .o_p(p_b2y));
    lix_mul #(.WA(W1), .WB(W1)) u_m_a1b2 (.i_clk, .i_en(en), .i_a(r_a1),
        .i_b(r_b2), .o_p(p_a1b2));
    lix_mul #(.WA(W1), .WB(W1)) u_m_a2b1 (.i_clk, .i_en(en), .i_a(r_a2),
        .i_b(r_b1), .o_p(p_a2b1));

    // Hold coefficients until the c terms are ready.
    logic [4*W1-1:0] ab_dly;
    logic signed [W1-1:0] d_a1, d_b1, d_a2, d_b2;

    lix_dly #(.WIDTH(4 * W1), .DEPTH(D_AB)) u_dly_ab (
        .i_clk, .i_rst_n, .i_en(en),
        .i_d({r_a1, r_b1, r_a2, r_b2}), .o_q(ab_dly));

    assign d_a1 = $signed(ab_dly[3*W1 +: W1]);
    assign d_b1 = $signed(ab_dly[2*W1 +: W1]);
    assign d_a2 = $signed(ab_dly[W1 +: W1]);
    assign d_b2 = $signed(ab_dly[0 +: W1]);

    // ---------------- Stage 1: sum the products
    logic signed [WC-1:0] r_c1, r_c2, r_det;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1  <= WC'(p_a1x) + WC'(p_b1y);
            r_c2  <= WC'(p_a2x) + WC'(p_b2y);
            r_det <= WC'(p_a1b2) - WC'(p_a2b1);
        end
    end

    // ---------------- M2: Cramer numerators
    logic signed [WX3-1:0] p_b2c1, p_b1c2, p_a1c2, p_a2c1;

    lix_mul #(.WA(WC), .WB(W1)) u_m_b2c1 (.i_clk, .i_en(en), .i_a(r_c1),
        .i_b(d_b2), .o_p(p_b2c1));
    lix_mul #(.WA(WC), .WB(W1)) u_m_b1c2 (.i_clk, .i_en(en), .i_a(r_c2),
        .i_b(d_b1), .o_p(p_b1c2));
    lix_mul #(.WA(WC), .WB(W1)) u_m_a1c2 (.i_clk, .i_en(en), .i_a(r_c2),
        .i_b(d_a1), .o_p(p_a1c2));
    lix_mul #(.WA(WC), .WB(W1)) u_m_a2c1 (.i_clk, .i_en(en), .i_a(r_c1),
        .i_b(d_a2), .o_p(p_a2c1));

    logic [WC-1:0] det_dly;

    lix_dly #(.WIDTH(WC), .DEPTH(D_DET)) u_dly_det (
        .i_clk, .i_rst_n, .i_en(en), .i_d(r_det), .o_q(det_dly));

    // ---------------- Stage 2: numerators, parallel test
    logic signed [WNX-1:0] r_nx, r_ny;
    logic signed [WC-1:0]  r_det2;
    logic                  r_found2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx     <= WNX'(p_b2c1) - WNX'(p_b1c2);
            r_ny     <= WNX'(p_a1c2) - WNX'(p_a2c1);
            r_det2   <= $signed(det_dly);
            r_found2 <= (det_dly != '0);
        end
    end

    // ---------------- D1: crossing point
    logic signed [W-1:0] q_x, q_y;

    lix_div #(.WN(WNX), .WD(WC), .WQ(W)) u_div_x (
        .i_clk, .i_en(en), .i_n(r_nx), .i_d(r_det2), .o_q(q_x));
    lix_div #(.WN(WNX), .WD(WC), .WQ(W)) u_div_y (
        .i_clk, .i_en(en), .i_n(r_ny), .i_d(r_det2), .o_q(q_y));

    // Hold the original points until the crossing point is known.
    logic [8*W-1:0] crd_dly;
    logic signed [W-1:0] d_sx1, d_sy1, d_ex1, d_ey1, d_sx2, d_sy2, d_ex2, d_ey2;

    lix_dly #(.WIDTH(8 * W), .DEPTH(D_CRD)) u_dly_crd (
        .i_clk, .i_rst_n, .i_en(en),
        .i_d({r_sx1, r_sy1, r_ex1, r_ey1, r_sx2, r_sy2, r_ex2, r_ey2}),
        .o_q(crd_dly));

    assign d_sx1 = $signed(crd_dly[7*W +: W]);
    assign d_sy1 = $signed(crd_dly[6*W +: W]);
    assign d_ex1 = $signed(crd_dly[5*W +: W]);
    assign d_ey1 = $signed(crd_dly[4*W +: W]);
    assign d_sx2 = $signed(crd_dly[3*W +: W]);
    assign d_sy2 = $signed(crd_dly[2*W +: W]);
    assign d_ex2 = $signed(crd_dly[W +: W]);
    assign d_ey2 = $signed(crd_dly[0 +: W]);

    // ---------------- Stage 3: offsets of the saturated point and directions
    logic signed [W1-1:0] r_px1, r_py1, r_dx1, r_dy1, r_px2, r_py2, r_dx2, r_dy2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px1 <= W1'(q_x) - W1'(d_sx1);
            r_py1 <= W1'(q_y) - W1'(d_sy1);
            r_dx1 <= W1'(d_ex1) - W1'(d_sx1);
            r_dy1 <= W1'(d_ey1) - W1'(d_sy1);
            r_px2 <= W1'(q_x) - W1'(d_sx2);
            r_py2 <= W1'(q_y) - W1'(d_sy2);
            r_dx2 <= W1'(d_ex2) - W1'(d_sx2);
            r_dy2 <= W1'(d_ey2) - W1'(d_sy2);
        end
    end

    // ---------------- M3: dot products and squared lengths
    logic signed [WM-1:0] p_pdx1, p_pdy1, p_dxx1, p_dyy1, p_pdx2, p_pdy2, p_dxx2, p_dyy2;

    lix_mul #(.WA(W1), .WB(W1)) u_m_pdx1 (.i_clk, .i_en(en), .i_a(r_px1),
        .i_b(r_dx1), .o_p(p_pdx1));
    lix_mul #(.WA(W1), .WB(W1)) u_m_pdy1 (.i_clk, .i_en(en), .i_a(r_py1),
        .i_b(r_dy1), .o_p(p_pdy1));
    lix_mul #(.WA(W1), .WB(W1)) u_m_dxx1 (.i_clk, .i_en(en), .i_a(r_dx1),
        .i_b(r_dx1), .o_p(p_dxx1));
    lix_mul #(.WA(W1), .WB(W1)) u_m_dyy1 (.i_clk, .i_en(en), .i_a(r_dy1),
        .i_b(r_dy1), .o_p(p_dyy1));
    lix_mul #(.WA(W1), .WB(W1)) u_m_pdx2 (.i_clk, .i_en(en), .i_a(r_px2),
        .i_b(r_dx2), .o_p(p_pdx2));
    lix_mul #(.WA(W1), .WB(W1)) u_m_pdy2 (.i_clk, .i_en(en), .i_a(r_py2),
        .i_b(r_dy2), .o_p(p_pdy2));
    lix_mul #(.WA(W1), .WB(W1)) u_m_dxx2 (.i_clk, .i_en(en), .i_a(r_dx2),
        .i_b(r_dx2), .o_p(p_dxx2));
    lix_mul #(.WA(W1), .WB(W1)) u_m_dyy2 (.i_clk, .i_en(en), .i_a(r_dy2),
        .i_b(r_dy2), .o_p(p_dyy2));

    // ---------------- Stage 4: scale the dot products by the fraction width, sum the squared lengths
    logic signed [WC-1:0]  dot1, dot2;
    logic signed [WNP-1:0] r_num1, r_num2;
    logic signed [WC-1:0]  r_den1, r_den2;

    assign dot1 = WC'(p_pdx1) + WC'(p_pdy1);
    assign dot2 = WC'(p_pdx2) + WC'(p_pdy2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num1 <= WNP'(dot1) <<< FRAC_BITS;
            r_num2 <= WNP'(dot2) <<< FRAC_BITS;
            r_den1 <= WC'(p_dxx1) + WC'(p_dyy1);
            r_den2 <= WC'(p_dxx2) + WC'(p_dyy2);
        end
    end

    // ---------------- D2: line parameters
    logic signed [W-1:0] q_t1, q_t2;

    lix_div #(.WN(WNP), .WD(WC), .WQ(W)) u_div_t1 (
        .i_clk, .i_en(en), .i_n(r_num1), .i_d(r_den1), .o_q(q_t1));
    lix_div #(.WN(WNP), .WD(WC), .WQ(W)) u_div_t2 (
        .i_clk, .i_en(en), .i_n(r_num2), .i_d(r_den2), .o_q(q_t2));

    // Carry the point, the found flag and the valid bit alongside.
    logic [2*W-1:0] xy_dly;
    logic           found_dly;
    logic           valid_dly;

    lix_dly #(.WIDTH(2 * W), .DEPTH(D_XY)) u_dly_xy (
        .i_clk, .i_rst_n, .i_en(en), .i_d({q_x, q_y}), .o_q(xy_dly));
    lix_dly #(.WIDTH(1), .DEPTH(D_FOUND)) u_dly_found (
        .i_clk, .i_rst_n, .i_en(en), .i_d(r_found2), .o_q(found_dly));
    lix_dly #(.WIDTH(1), .DEPTH(D_VALID)) u_dly_valid (
        .i_clk, .i_rst_n, .i_en(en), .i_d(r_v0), .o_q(valid_dly));

    // ---------------- Output register: drop all fields to zero when parallel
    logic                r_out_v;
    logic                r_out_found;
    logic signed [W-1:0] r_out_x, r_out_y, r_out_t1, r_out_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= valid_dly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_found <= found_dly;
            r_out_x     <= found_dly ? $signed(xy_dly[W +: W]) : '0;
            r_out_y     <= found_dly ? $signed(xy_dly[0 +: W]) : '0;
            r_out_t1    <= found_dly ? q_t1 : '0;
            r_out_t2    <= found_dly ? q_t2 : '0;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.found        = r_out_found;
    assign o_out.cross_x      = r_out_x;
    assign o_out.cross_y      = r_out_y;
    assign o_out.first_param  = r_out_t1;
    assign o_out.second_param = r_out_t2;

    // ---------------- Checks
    logic out_zero;
    logic out_held;
    logic in_take;

    assign out_zero = (r_out_x == '0) && (r_out_y == '0) && (r_out_t1 == '0)
                      && (r_out_t2 == '0);
    assign out_held = o_out.valid && !o_out.ready;
    assign in_take  = i_in.valid && i_in.ready;

    `LIX_ASSERT_IMPL(a_zero_when_parallel, i_clk, i_rst_n, o_out.valid && !o_out.found, out_zero)
    `LIX_ASSERT_IMPL(a_held_output_blocks_input, i_clk, i_rst_n, out_held, !i_in.ready)
    `LIX_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, in_take, r_v0)
endmodule

@@ bench/tb_line_intersection_2d_core.sv @@
`timescale 1ns / 100ps

module tb_line_intersection_2d_core;
    import lix_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 3 * ((CB + 1 + 15) / 16) + 2 * (CB + 3) + 5;
    localparam int MAX_CYCLES = 1000000;

    typedef logic signed [CB-1:0] t_coord;
    // Wide enough for every exact product and the shifted projection numerator.
    typedef logic signed [255:0] t_big;

    typedef struct packed {
        t_coord s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    } t_query;

    typedef struct packed {
        logic   found;
        t_coord cross_x, cross_y, first_param, second_param;
    } t_crossing;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lix_in_if  #(.COORD_BITS(CB)) in_ch ();
    lix_out_if #(.COORD_BITS(CB)) out_ch ();

    line_intersection_2d_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_crossing pending_crossings[$];
    int        n_errors = 0;
    int        cycle_count = 0;
    int        hold_off_cycles = 0;
    int        send_idle_pct = 28;
    int        recv_idle_pct = 28;

    // Clamp a wide quotient to the coordinate range.
    function automatic t_coord clamp_coord(t_big v);
        t_big hi, lo;
        hi = t_big'({1'b0, {(CB-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) return hi[CB-1:0];
        if (v < lo) return lo[CB-1:0];
        return v[CB-1:0];
    endfunction

    // Signed division truncating toward zero; zero divisor gives zero.
    function automatic t_big div_trunc(t_big n, t_big d);
        if (d == 0) return 0;
        return n / d;
    endfunction

    function automatic t_coord line_param(t_big px, t_big py, t_big sx, t_big sy,
                                          t_big ex, t_big ey);
        t_big dx, dy, num, den;
        dx  = ex - sx;
        dy  = ey - sy;
        num = (px - sx) * dx + (py - sy) * dy;
        den = dx * dx + dy * dy;
        if (den == 0) return '0;
        return clamp_coord(div_trunc(num <<< FB, den));
    endfunction

    function automatic t_crossing predict_crossing(t_query q);
        t_crossing r;
        t_big ax, ay, bx, by, cx, cy, dx, dy;
        t_big a1, b1, c1, a2, b2, c2, det;
        ax = q.s1x; ay = q.s1y; bx = q.e1x; by = q.e1y;
        cx = q.s2x; cy = q.s2y; dx = q.e2x; dy = q.e2y;
        a1 = by - ay; b1 = ax - bx; c1 = a1 * ax + b1 * ay;
        a2 = dy - cy; b2 = cx - dx; c2 = a2 * cx + b2 * cy;
        det = a1 * b2 - a2 * b1;
        r = '0;
        if (det == 0) return r;
        r.found   = 1'b1;
        r.cross_x = clamp_coord(div_trunc(b2 * c1 - b1 * c2, det));
        r.cross_y = clamp_coord(div_trunc(a1 * c2 - a2 * c1, det));
        // Parameters use the point as it leaves the block, already clamped.
        r.first_param  = line_param(t_big'(r.cross_x), t_big'(r.cross_y), ax, ay, bx, by);
        r.second_param = line_param(t_big'(r.cross_x), t_big'(r.cross_y), cx, cy, dx, dy);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    // Drive every input to a known value from time zero.
    initial begin
        in_ch.valid = 1'b0;
        {in_ch.first_start_x, in_ch.first_start_y, in_ch.first_end_x, in_ch.first_end_y,
         in_ch.second_start_x, in_ch.second_start_y, in_ch.second_end_x,
         in_ch.second_end_y} = '0;
        out_ch.ready = 1'b0;
    end

    // Run limit: count cycles, end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("tb_line_intersection_2d_core NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_crossings.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                want = pending_crossings.pop_front();
                if (out_ch.found !== want.found)
                    report_mismatch("found", CB'(out_ch.found), CB'(want.found));
                if (out_ch.cross_x !== want.cross_x)
                    report_mismatch("cross_x", out_ch.cross_x, want.cross_x);
                if (out_ch.cross_y !== want.cross_y)
                    report_mismatch("cross_y", out_ch.cross_y, want.cross_y);
                if (out_ch.first_param !== want.first_param)
                    report_mismatch("first_param", out_ch.first_param, want.first_param);
                if (out_ch.second_param !== want.second_param)
                    report_mismatch("second_param", out_ch.second_param, want.second_param);
            end
        end
    end

    // Offer one item, holding it until accepted; random idle cycles first.
    task automatic send_query(t_query q);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pending_crossings.push_back(predict_crossing(q));
        in_ch.valid          <= 1'b1;
        in_ch.first_start_x  <= q.s1x;
        in_ch.first_start_y  <= q.s1y;
        in_ch.first_end_x    <= q.e1x;
        in_ch.first_end_y    <= q.e1y;
        in_ch.second_start_x <= q.s2x;
        in_ch.second_start_y <= q.s2y;
        in_ch.second_end_x   <= q.e2x;
        in_ch.second_end_y   <= q.e2y;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid after the last item of a burst.
    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_crossings.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord fx(int whole);
        return t_coord'(whole) <<< FB;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(4095)) - 2048;
            2: return fx($urandom_range(200)) - fx(100);
            3: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return t_coord'($urandom) >>> $urandom_range(20);
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(9))
            // Parallel: second line is the first shifted.
            0: begin
                q.s2x = q.s1x + fx(3); q.s2y = q.s1y - fx(1);
                q.e2x = q.e1x + fx(3); q.e2y = q.e1y - fx(1);
            end
            // Degenerate: a line collapsed to a point.
            1: begin q.e1x = q.s1x; q.e1y = q.s1y; end
            // Shared start point: crossing lands on a known point.
            2: begin q.s2x = q.s1x; q.s2y = q.s1y; end
            default: ;
        endcase
        return q;
    endfunction

    task automatic test_directed();
        t_coord mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // Plain cross through the origin.
        send_query({fx(-1), fx(0), fx(1), fx(0), fx(0), fx(-1), fx(0), fx(1)});
        // Parallel, collinear, and a collapsed line.
        send_query({fx(0), fx(0), fx(1), fx(1), fx(0), fx(1), fx(1), fx(2)});
        send_query({fx(0), fx(0), fx(1), fx(1), fx(2), fx(2), fx(3), fx(3)});
        send_query({fx(5), fx(5), fx(5), fx(5), fx(0), fx(0), fx(1), fx(3)});
        send_query('0);
        // Crossing far outside both segments and near-parallel overflow.
        send_query({fx(0), fx(0), fx(1), fx(0), fx(9), fx(4), fx(10), fx(5)});
        send_query({t_coord'(0), t_coord'(0), mx, t_coord'(1),
                    t_coord'(0), t_coord'(1), mx, t_coord'(3)});
        send_query({mn, mn, mx, mx, mn, mx, mx, mn});
        send_query({mx, mx, mx, mx, mn, mn, mn, mn});
        send_query({mx, mn, mn, mx, mx, mx, mn, mn});
        send_query({mn, 32'sd0, mx, 32'sd1, 32'sd0, mn, 32'sd1, mx});
        send_query({t_coord'(1), t_coord'(0), t_coord'(-1), t_coord'(0),
                    t_coord'(0), t_coord'(1), t_coord'(0), t_coord'(-1)});
        send_query({t_coord'('1), t_coord'('1), t_coord'(1), t_coord'(3),
                    t_coord'(7), t_coord'(-5), t_coord'(-3), t_coord'(9)});
        end_burst();
        wait_drained();
    endtask

    task automatic test_random(int n);
        repeat (n) send_query(rand_query());
        end_burst();
    endtask

    // Back-to-back with no idling on either side.
    task automatic test_full_rate(int n);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (n) send_query(rand_query());
        end_burst();
        wait_drained();
        send_idle_pct = 28;
        recv_idle_pct = 28;
    endtask

    // Hold the receiver off long enough to fill the pipeline and stall input.
    task automatic test_backpressure(int n);
        hold_off_cycles = 3 * LATENCY;
        send_idle_pct = 0;
        repeat (n) send_query(rand_query());
        end_burst();
        send_idle_pct = 28;
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600);
        wait_drained();
        test_full_rate(250);
        test_backpressure(200);
        test_random(390);

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && pending_crossings.size() == 0) begin
            $display("tb_line_intersection_2d_core OK");
        end else begin
            $display("tb_line_intersection_2d_core NOT OK");
        end
        $finish;
    end
endmodule
